// ===== src/irdl_pkg.sv =====
// ----------------------------------------------------------------------------
// irdl_pkg
// Shared constants, calibration tables and controller/datapath bundles for
// the infrared distance linearizer.
// ----------------------------------------------------------------------------
`default_nettype none

package irdl_pkg;

  localparam int TABLE_LEN    = 31;
  localparam int NUM_CHANNELS = 4;

  localparam int CH_W      = 2;
  localparam int SAMPLE_W  = 12;
  localparam int DIST_W    = 13;
  localparam int ENTRY_W   = 8;
  localparam int IDX_W     = $clog2(TABLE_LEN);
  localparam int SCALE_W   = 8;
  localparam int NUM_W     = ENTRY_W + SCALE_W;
  localparam int DIV_CNT_W = $clog2(SCALE_W);

  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 16;
  localparam int M_TUSER_W = 2;

  // One table step is 10 mm, i.e. 160 sixteenths.
  localparam logic [DIST_W-1:0] STEP_SIXTEENTHS   = DIST_W'(160);
  localparam logic [DIST_W-1:0] OFFSET_SIXTEENTHS = DIST_W'(160);
  localparam logic [DIST_W-1:0] BEYOND_DIST       = DIST_W'(160 * TABLE_LEN);

  localparam logic [ENTRY_W-1:0] CAL_ROM [NUM_CHANNELS][TABLE_LEN] = '{
    '{8'd1,   8'd13,  8'd31,  8'd47,  8'd64,  8'd77,  8'd89,  8'd99,
      8'd106, 8'd113, 8'd118, 8'd123, 8'd128, 8'd132, 8'd137, 8'd139,
      8'd141, 8'd144, 8'd148, 8'd151, 8'd153, 8'd155, 8'd156, 8'd158,
      8'd159, 8'd161, 8'd161, 8'd162, 8'd164, 8'd164, 8'd166},
    '{8'd7,   8'd21,  8'd36,  8'd52,  8'd65,  8'd76,  8'd83,  8'd92,
      8'd98,  8'd106, 8'd111, 8'd115, 8'd119, 8'd124, 8'd125, 8'd129,
      8'd133, 8'd136, 8'd138, 8'd140, 8'd143, 8'd144, 8'd147, 8'd148,
      8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154, 8'd154},
    '{8'd0,   8'd17,  8'd34,  8'd46,  8'd60,  8'd69,  8'd78,  8'd85,
      8'd92,  8'd98,  8'd103, 8'd109, 8'd114, 8'd119, 8'd123, 8'd128,
      8'd131, 8'd135, 8'd139, 8'd142, 8'd145, 8'd149, 8'd150, 8'd154,
      8'd156, 8'd159, 8'd162, 8'd164, 8'd166, 8'd169, 8'd171},
    '{8'd0,   8'd12,  8'd31,  8'd40,  8'd52,  8'd63,  8'd71,  8'd80,
      8'd87,  8'd93,  8'd97,  8'd105, 8'd112, 8'd117, 8'd213, 8'd127,
      8'd132, 8'd128, 8'd143, 8'd149, 8'd154, 8'd159, 8'd162, 8'd167,
      8'd171, 8'd177, 8'd182, 8'd187, 8'd193, 8'd199, 8'd203}
  };

  typedef struct packed {
    logic load;
    logic step_k;
    logic div_init;
    logic div_step;
    logic set_below;
    logic set_beyond;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic below;
    logic match;
    logic last_seg;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ===== src/irdl_ctrl.sv =====
// ----------------------------------------------------------------------------
// irdl_ctrl
// Sequencer: accepts an item, walks the segments, runs the serial divide and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module irdl_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire irdl_pkg::status_t status_i,
  output irdl_pkg::cmd_t        cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StDivide = 2'd2;
  localparam logic [1:0] StDone   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StSearch;
        end
      end
      StSearch: begin
        if (status_i.below) begin
          cmd_o.set_below = 1'b1;
          state_d         = StDone;
        end else if (status_i.match) begin
          cmd_o.div_init = 1'b1;
          state_d        = StDivide;
        end else if (status_i.last_seg) begin
          cmd_o.set_beyond = 1'b1;
          state_d          = StDone;
        end else begin
          cmd_o.step_k = 1'b1;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        // The previous result must have left the output register first.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/irdl_datapath.sv =====
// ----------------------------------------------------------------------------
// irdl_datapath
// Segment search over the calibration table, restoring divider for the
// in-segment fraction, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module irdl_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire irdl_pkg::cmd_t                cmd_i,
  output irdl_pkg::status_t                  status_o,
  input  wire logic [irdl_pkg::CH_W-1:0]     channel_i,
  input  wire logic [irdl_pkg::SAMPLE_W-1:0] sample_i,
  output logic [irdl_pkg::DIST_W-1:0]        distance_o,
  output logic                               below_o,
  output logic                               beyond_o
);

  logic [irdl_pkg::CH_W-1:0]      ch_q;
  logic [irdl_pkg::SAMPLE_W-1:0]  sample_q;
  logic [irdl_pkg::IDX_W-1:0]     k_q;
  logic [irdl_pkg::ENTRY_W-1:0]   span_q;
  logic [irdl_pkg::ENTRY_W-1:0]   rem_q;
  logic [irdl_pkg::SCALE_W-1:0]   num_q;
  logic [irdl_pkg::SCALE_W-1:0]   quo_q;
  logic [irdl_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           below_q;
  logic                           beyond_q;
  logic [irdl_pkg::DIST_W-1:0]    dist_out_q;
  logic                           below_out_q;
  logic                           beyond_out_q;

  logic [irdl_pkg::CH_W-1:0]    ch_clamped;
  logic [irdl_pkg::ENTRY_W-1:0] lo;
  logic [irdl_pkg::ENTRY_W-1:0] hi;
  logic [irdl_pkg::ENTRY_W-1:0] diff;
  logic [irdl_pkg::NUM_W-1:0]   num;
  logic [irdl_pkg::ENTRY_W:0]   trial;
  logic                         ge;
  logic [irdl_pkg::DIST_W-1:0]  dist_base;
  logic [irdl_pkg::DIST_W-1:0]  dist_total;

  always_comb begin
    if (int'(channel_i) >= irdl_pkg::NUM_CHANNELS) begin
      ch_clamped = irdl_pkg::CH_W'(irdl_pkg::NUM_CHANNELS - 1);
    end else begin
      ch_clamped = channel_i;
    end
  end

  assign lo = irdl_pkg::CAL_ROM[ch_q][k_q];
  assign hi = irdl_pkg::CAL_ROM[ch_q][k_q + irdl_pkg::IDX_W'(1)];

  assign status_o.below    = (k_q == '0) && (sample_q < irdl_pkg::SAMPLE_W'(lo));
  assign status_o.match    = (irdl_pkg::SAMPLE_W'(lo) <= sample_q) &&
                             (irdl_pkg::SAMPLE_W'(hi) > sample_q);
  assign status_o.last_seg = (k_q == irdl_pkg::IDX_W'(irdl_pkg::TABLE_LEN - 2));
  assign status_o.div_last = (cnt_q == '1);

  // On a match the sample lies below hi, so the offset fits an entry.
  assign diff = irdl_pkg::ENTRY_W'(sample_q - irdl_pkg::SAMPLE_W'(lo));
  assign num  = irdl_pkg::NUM_W'(diff) * irdl_pkg::NUM_W'(irdl_pkg::STEP_SIXTEENTHS);

  // The quotient is below 160, so the upper numerator byte is already
  // smaller than the span and only eight quotient bits remain to find.
  assign trial = {rem_q, num_q[irdl_pkg::SCALE_W-1]};
  assign ge    = (trial >= {1'b0, span_q});

  always_comb begin
    if (below_q) begin
      dist_base = '0;
    end else if (beyond_q) begin
      dist_base = irdl_pkg::BEYOND_DIST;
    end else begin
      dist_base = irdl_pkg::DIST_W'(irdl_pkg::DIST_W'(k_q) * irdl_pkg::STEP_SIXTEENTHS) +
                  irdl_pkg::DIST_W'(quo_q);
    end
    if (!beyond_q && (ch_q == irdl_pkg::CH_W'(0) || ch_q == irdl_pkg::CH_W'(1))) begin
      dist_total = dist_base + irdl_pkg::OFFSET_SIXTEENTHS;
    end else begin
      dist_total = dist_base;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      cnt_q    <= '0;
      below_q  <= 1'b0;
      beyond_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        k_q      <= '0;
        below_q  <= 1'b0;
        beyond_q <= 1'b0;
      end
      if (cmd_i.step_k) begin
        k_q <= k_q + irdl_pkg::IDX_W'(1);
      end
      if (cmd_i.set_below) begin
        below_q <= 1'b1;
      end
      if (cmd_i.set_beyond) begin
        beyond_q <= 1'b1;
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + irdl_pkg::DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q     <= ch_clamped;
      sample_q <= sample_i;
    end
    if (cmd_i.div_init) begin
      span_q <= hi - lo;
      rem_q  <= num[irdl_pkg::NUM_W-1 -: irdl_pkg::ENTRY_W];
      num_q  <= num[irdl_pkg::SCALE_W-1:0];
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= irdl_pkg::ENTRY_W'(trial - {1'b0, span_q});
      end else begin
        rem_q <= irdl_pkg::ENTRY_W'(trial);
      end
      num_q <= {num_q[irdl_pkg::SCALE_W-2:0], 1'b0};
      quo_q <= {quo_q[irdl_pkg::SCALE_W-2:0], ge};
    end
    if (cmd_i.out_load) begin
      dist_out_q   <= dist_total;
      below_out_q  <= below_q;
      beyond_out_q <= beyond_q;
    end
  end

  assign distance_o = dist_out_q;
  assign below_o    = below_out_q;
  assign beyond_o   = beyond_out_q;

endmodule

`default_nettype wire

// ===== src/ir_distance_linearizer.sv =====
// Sequence: after an input transfer the sequencer searches one segment per
//   cycle (k+1 search steps when segment k matches), runs the 8 divide steps
//   and loads the result register; below or beyond the table it skips the divide.
// Flow: one item at a time, set by the segment search and the bit-serial divider;
//   the result register lets a new item in, but a full one holds the sequencer.
// Reset: rst_ni clears the sequencer and the output valid; there is no table state.
// ----------------------------------------------------------------------------
// ir_distance_linearizer
// Converts a raw infrared reading into a distance in sixteenths of a
// millimeter by piecewise linear interpolation over per-channel tables.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_distance_linearizer (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [irdl_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [11:0] sample
  input  wire logic [irdl_pkg::S_TUSER_W-1:0] s_axis_tuser,  // [1:0] channel
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [irdl_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [12:0] distance_sixteenths
  output logic [irdl_pkg::M_TUSER_W-1:0]      m_axis_tuser   // [0] below_table, [1] beyond_table
);

  irdl_pkg::cmd_t                cmd;
  irdl_pkg::status_t             status;
  logic [irdl_pkg::DIST_W-1:0]   distance;
  logic                          below;
  logic                          beyond;

  irdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  irdl_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .channel_i  (s_axis_tuser[irdl_pkg::CH_W-1:0]),
    .sample_i   (s_axis_tdata[irdl_pkg::SAMPLE_W-1:0]),
    .distance_o (distance),
    .below_o    (below),
    .beyond_o   (beyond)
  );

  assign m_axis_tdata = irdl_pkg::M_TDATA_W'(distance);
  assign m_axis_tuser = {beyond, below};

`ifndef SYNTHESIS
  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("below and beyond flags both set");

  a_beyond_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> distance == irdl_pkg::BEYOND_DIST)
    else $error("beyond-table result has wrong distance");

  a_below_distance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (distance == '0 || distance == irdl_pkg::OFFSET_SIXTEENTHS))
    else $error("below-table result has wrong distance");
`endif

endmodule

`default_nettype wire
